/* src/particle_pool_update_defines.svh */
// Assertion macros for the particle pool checker.
// Expects clk_i and rst_ni in the scope of use.
`ifndef PARTICLE_POOL_UPDATE_DEFINES_SVH
`define PARTICLE_POOL_UPDATE_DEFINES_SVH

// same-cycle implication
`define PPU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("particle_pool_update: check failed");

// next-cycle implication
`define PPU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("particle_pool_update: check failed");

`endif

/* src/ppu_pkg.sv */
// Particle pool package: payload structs, ALU control, constants, helper functions.
// No dependencies.
`timescale 1ns / 1ps
package ppu_pkg;

  localparam int SLOT_W     = 6;
  localparam int POS_W      = 32;
  localparam int GREY_W     = 9;
  localparam int ALPHA_W    = 17;
  localparam int LIFE_W     = 18;
  localparam int DT_W       = 16;
  localparam int VEL_W      = 16;
  localparam int FADE_W     = 16;
  localparam int SLIFE_W    = 17;
  localparam int RAND_W     = 7;
  localparam int JIT_W      = 12;
  localparam int DELTA_W    = 18;
  localparam int ALU_W      = 34;
  localparam int MUL_W      = 17;
  localparam int RND_SHIFT  = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic CMD_SPAWN = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [1:0] KIND_SPAWN = 2'd0;
  localparam logic [1:0] KIND_LIVE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_VEL_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FADE_RATE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAWN_LIFE = 2'd3;

  localparam logic signed [VEL_W-1:0] VEL_RESET   = 16'sd12800;
  localparam logic [FADE_W-1:0]       FADE_RESET  = 16'd1638;
  localparam logic [SLIFE_W-1:0]      SLIFE_RESET = 17'h10000;
  localparam logic [ALPHA_W-1:0]      ALPHA_FULL  = 17'h10000;

  localparam logic signed [ALU_W-1:0] S32_MAX    = 34'sh0_7FFF_FFFF;
  localparam logic signed [ALU_W-1:0] S32_MIN    = 34'sh3_8000_0000;
  localparam logic signed [ALU_W-1:0] LIFE_MIN   = 34'sh3_FFFE_0000;
  localparam logic signed [ALU_W-1:0] ROUND_HALF = 34'sd32768;

  // reciprocals: x/5 for x < 2^14 and x/25 for x < 2^13 are exact
  localparam logic [15:0] RECIP_5  = 16'd13108;
  localparam logic [15:0] RECIP_25 = 16'd41944;
  localparam logic [7:0]  JIT_BIAS = 8'd50;
  localparam logic [8:0]  GREY_BASE = 9'd128;

  typedef struct packed {
    logic                     command;
    logic [DT_W-1:0]          time_step;
    logic signed [POS_W-1:0]  producer_x;
    logic signed [POS_W-1:0]  producer_y;
    logic signed [POS_W-1:0]  offset_x;
    logic signed [POS_W-1:0]  offset_y;
    logic [RAND_W-1:0]        jitter_random;
    logic [RAND_W-1:0]        grey_random;
  } in_t;

  typedef struct packed {
    logic [1:0]               result_kind;
    logic [SLOT_W-1:0]        slot;
    logic signed [POS_W-1:0]  position_x;
    logic signed [POS_W-1:0]  position_y;
    logic [GREY_W-1:0]        grey_level;
    logic [ALPHA_W-1:0]       alpha;
    logic                     last;
  } out_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic [FADE_W-1:0]       fade_rate;
    logic [SLIFE_W-1:0]      spawn_life;
  } cfg_t;

  typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_RND} alu_op_e;
  typedef enum logic [1:0] {SAT_NONE, SAT_S32, SAT_ZERO, SAT_LIFE} sat_e;

  typedef struct packed {
    alu_op_e op;
    sat_e    sat;
  } alu_ctl_t;

  // 256*(r-50)/10, rounded to nearest
  function automatic logic signed [JIT_W-1:0] jitter_of(input logic [RAND_W-1:0] r);
    logic signed [RAND_W:0] d;
    logic [RAND_W-1:0]      mag_r;
    logic [13:0]            mag;
    logic [29:0]            q;
    logic [JIT_W-1:0]       qt;
    d     = $signed({1'b0, r}) - $signed(JIT_BIAS);
    mag_r = d[RAND_W] ? RAND_W'(-d) : d[RAND_W-1:0];
    mag   = {mag_r, 7'b0} + 14'd2;
    q     = 30'(mag) * 30'(RECIP_5);
    qt    = JIT_W'(q[29:16]);
    return d[RAND_W] ? -$signed(qt) : $signed(qt);
  endfunction

  // 128 + 256*r/100, rounded to nearest
  function automatic logic [GREY_W-1:0] grey_of(input logic [RAND_W-1:0] r);
    logic [12:0] x;
    logic [28:0] q;
    x = {r, 6'b0} + 13'd12;
    q = 29'(x) * 29'(RECIP_25);
    return GREY_BASE + q[28:20];
  endfunction

endpackage

/* src/ppu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ppu_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ppu_alu.sv */
// Shared arithmetic unit: add, subtract, 17x17 multiply, round-shift, saturation.
// Depends on ppu_pkg.
`timescale 1ns / 1ps
module ppu_alu (
  input  logic signed [ppu_pkg::ALU_W-1:0] a_i,
  input  logic signed [ppu_pkg::ALU_W-1:0] b_i,
  input  ppu_pkg::alu_ctl_t                ctl_i,
  output logic signed [ppu_pkg::ALU_W-1:0] y_o
);
  import ppu_pkg::*;

  logic signed [MUL_W-1:0] ma;
  logic signed [MUL_W-1:0] mb;
  logic signed [ALU_W-1:0] rnd_sum;
  logic signed [ALU_W-1:0] raw;

  assign ma      = a_i[MUL_W-1:0];
  assign mb      = b_i[MUL_W-1:0];
  assign rnd_sum = a_i + ROUND_HALF;

  always_comb begin
    unique case (ctl_i.op)
      ALU_ADD: raw = a_i + b_i;
      ALU_SUB: raw = a_i - b_i;
      ALU_MUL: raw = ma * mb;
      ALU_RND: raw = rnd_sum >>> RND_SHIFT;
    endcase
  end

  always_comb begin
    y_o = raw;
    unique case (ctl_i.sat)
      SAT_NONE: y_o = raw;
      SAT_S32: begin
        if (raw > S32_MAX) begin
          y_o = S32_MAX;
        end else if (raw < S32_MIN) begin
          y_o = S32_MIN;
        end
      end
      SAT_ZERO: begin
        if (raw[ALU_W-1]) begin
          y_o = '0;
        end
      end
      SAT_LIFE: begin
        if (raw < LIFE_MIN) begin
          y_o = LIFE_MIN;
        end
      end
    endcase
  end

endmodule

/* src/ppu_cfg.sv */
// Configuration register file for the particle pool.
// Depends on ppu_pkg.
`timescale 1ns / 1ps
module ppu_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]    index_i,
  input  logic [ppu_pkg::CFG_DATA_W-1:0]   data_i,
  output ppu_pkg::cfg_t                    cfg_o
);
  import ppu_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vel_x      <= VEL_RESET;
      cfg_q.vel_y      <= VEL_RESET;
      cfg_q.fade_rate  <= FADE_RESET;
      cfg_q.spawn_life <= SLIFE_RESET;
    end else if (we_i) begin
      unique case (index_i)
        CFG_VEL_X:      cfg_q.vel_x      <= data_i[VEL_W-1:0];
        CFG_VEL_Y:      cfg_q.vel_y      <= data_i[VEL_W-1:0];
        CFG_FADE_RATE:  cfg_q.fade_rate  <= data_i[FADE_W-1:0];
        CFG_SPAWN_LIFE: cfg_q.spawn_life <= data_i[SLIFE_W-1:0];
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/particle_pool_update.sv */
// Particle pool top level: sequencer over the shared ALU and the per-slot RAMs.
// Depends on ppu_pkg, ppu_ram, ppu_alu, ppu_cfg.
//
//   channel   | direction | handshake                      | payload
//   ----------+-----------+--------------------------------+-------------------------
//   command   | in        | start & !busy                  | item_i (in_t)
//   result    | out       | res_strobe_o, one cycle each   | res_o (out_t)
//   config    | in        | cfg_valid_i & cfg_ready_o      | cfg_index_i, cfg_data_i
//
// Spawn: a dead-slot search, then X1, X2, Y1, Y2; the one result is strobed as busy falls.
// Tick: a setup of three multiply/round pairs on the ALU, then per slot a RAM read and
// life step, plus x, y and alpha if live, then a closing step.
// Position, life and alpha math use the single ALU; busy is high for the whole item.
// Reset marks every slot dead through per-slot alive flops; no clearing pass.
// Results are strobed and cannot be stalled.
`timescale 1ns / 1ps
module particle_pool_update #(
  parameter int POOL_SIZE = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  ppu_pkg::in_t                   item_i,
  output logic                           res_strobe_o,
  output ppu_pkg::out_t                  res_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ppu_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ppu_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ppu_pkg::*;

  localparam int IdxW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(POOL_SIZE - 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SEARCH, ST_X1, ST_X2, ST_Y1, ST_Y2,
    ST_MVX, ST_RVX, ST_MVY, ST_RVY, ST_MFD, ST_RFD,
    ST_RD, ST_LIFE, ST_PX, ST_PY, ST_AL, ST_END
  } state_e;

  state_e                   state_q;
  in_t                      item_q;
  logic [IdxW-1:0]          idx_q;
  logic [IdxW-1:0]          cnt_q;
  logic [IdxW-1:0]          srch_q;
  logic [POOL_SIZE-1:0]     alive_q;
  logic signed [ALU_W-1:0]  acc_q;
  logic signed [DELTA_W-1:0] dx_q;
  logic signed [DELTA_W-1:0] dy_q;
  logic [ALPHA_W-1:0]       fade_q;
  logic signed [POS_W-1:0]  px_q;
  logic signed [POS_W-1:0]  py_q;
  out_t                     pend_q;
  logic                     pend_v_q;
  out_t                     res_q;
  logic                     res_v_q;

  cfg_t                     cfg;
  alu_ctl_t                 alu_ctl;
  logic signed [ALU_W-1:0]  alu_a;
  logic signed [ALU_W-1:0]  alu_b;
  logic signed [ALU_W-1:0]  alu_y;

  logic [LIFE_W-1:0]  life_rd;
  logic [POS_W-1:0]   px_rd;
  logic [POS_W-1:0]   py_rd;
  logic [GREY_W-1:0]  grey_rd;
  logic [ALPHA_W-1:0] alpha_rd;

  logic               rd_en;
  logic               life_we;
  logic [LIFE_W-1:0]  life_wd;
  logic               px_we;
  logic               py_we;
  logic               grey_we;
  logic               alpha_we;
  logic [ALPHA_W-1:0] alpha_wd;
  logic [GREY_W-1:0]  grey_new;

  logic                    accept;
  logic                    idx_last;
  logic [IdxW-1:0]         idx_nxt;
  logic                    live_now;
  logic signed [JIT_W-1:0] jit;
  out_t                    cur_live;

  assign busy         = (state_q != ST_IDLE);
  assign accept       = start && !busy;
  assign cfg_ready_o  = 1'b1;
  assign res_strobe_o = res_v_q;
  assign res_o        = res_q;

  assign idx_last = (idx_q == LastIdx);
  assign idx_nxt  = idx_last ? '0 : idx_q + IdxW'(1);
  assign live_now = alive_q[idx_q] && !alu_y[ALU_W-1] && (alu_y != '0);
  assign jit      = jitter_of(item_q.jitter_random);
  assign grey_new = grey_of(item_q.grey_random);

  ppu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i && cfg_ready_o),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  always_comb begin
    alu_a   = acc_q;
    alu_b   = '0;
    alu_ctl = '{op: ALU_ADD, sat: SAT_NONE};
    unique case (state_q)
      ST_X1: begin
        alu_a = ALU_W'($signed(item_q.producer_x));
        alu_b = ALU_W'($signed(item_q.offset_x));
      end
      ST_Y1: begin
        alu_a = ALU_W'($signed(item_q.producer_y));
        alu_b = ALU_W'($signed(item_q.offset_y));
      end
      ST_X2, ST_Y2: begin
        alu_b   = ALU_W'(jit);
        alu_ctl = '{op: ALU_ADD, sat: SAT_S32};
      end
      ST_MVX: begin
        alu_a   = ALU_W'($signed(cfg.vel_x));
        alu_b   = ALU_W'(item_q.time_step);
        alu_ctl = '{op: ALU_MUL, sat: SAT_NONE};
      end
      ST_MVY: begin
        alu_a   = ALU_W'($signed(cfg.vel_y));
        alu_b   = ALU_W'(item_q.time_step);
        alu_ctl = '{op: ALU_MUL, sat: SAT_NONE};
      end
      ST_MFD: begin
        alu_a   = ALU_W'(cfg.fade_rate);
        alu_b   = ALU_W'(item_q.time_step);
        alu_ctl = '{op: ALU_MUL, sat: SAT_NONE};
      end
      ST_RVX, ST_RVY, ST_RFD: begin
        alu_ctl = '{op: ALU_RND, sat: SAT_NONE};
      end
      ST_LIFE: begin
        alu_a   = ALU_W'($signed(life_rd));
        alu_b   = ALU_W'(item_q.time_step);
        alu_ctl = '{op: ALU_SUB, sat: SAT_LIFE};
      end
      ST_PX: begin
        alu_a   = ALU_W'($signed(px_rd));
        alu_b   = ALU_W'(dx_q);
        alu_ctl = '{op: ALU_ADD, sat: SAT_S32};
      end
      ST_PY: begin
        alu_a   = ALU_W'($signed(py_rd));
        alu_b   = ALU_W'(dy_q);
        alu_ctl = '{op: ALU_ADD, sat: SAT_S32};
      end
      ST_AL: begin
        alu_a   = ALU_W'(alpha_rd);
        alu_b   = ALU_W'(fade_q);
        alu_ctl = '{op: ALU_SUB, sat: SAT_ZERO};
      end
      default: begin
        alu_a = acc_q;
      end
    endcase
  end

  ppu_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .ctl_i (alu_ctl),
    .y_o   (alu_y)
  );

  assign rd_en    = (state_q == ST_RD);
  assign life_we  = (state_q == ST_LIFE) || (state_q == ST_Y2);
  assign life_wd  = (state_q == ST_Y2) ? LIFE_W'(cfg.spawn_life) : alu_y[LIFE_W-1:0];
  assign px_we    = (state_q == ST_X2) || (state_q == ST_PX);
  assign py_we    = (state_q == ST_Y2) || (state_q == ST_PY);
  assign grey_we  = (state_q == ST_Y2);
  assign alpha_we = (state_q == ST_Y2) || (state_q == ST_AL);
  assign alpha_wd = (state_q == ST_Y2) ? ALPHA_FULL : alu_y[ALPHA_W-1:0];

  ppu_ram #(.Width(LIFE_W), .Depth(POOL_SIZE)) u_life_ram (
    .clk_i (clk_i), .we_i (life_we), .waddr_i (idx_q), .wdata_i (life_wd),
    .re_i (rd_en), .raddr_i (idx_q), .rdata_o (life_rd)
  );

  ppu_ram #(.Width(POS_W), .Depth(POOL_SIZE)) u_px_ram (
    .clk_i (clk_i), .we_i (px_we), .waddr_i (idx_q), .wdata_i (alu_y[POS_W-1:0]),
    .re_i (rd_en), .raddr_i (idx_q), .rdata_o (px_rd)
  );

  ppu_ram #(.Width(POS_W), .Depth(POOL_SIZE)) u_py_ram (
    .clk_i (clk_i), .we_i (py_we), .waddr_i (idx_q), .wdata_i (alu_y[POS_W-1:0]),
    .re_i (rd_en), .raddr_i (idx_q), .rdata_o (py_rd)
  );

  ppu_ram #(.Width(GREY_W), .Depth(POOL_SIZE)) u_grey_ram (
    .clk_i (clk_i), .we_i (grey_we), .waddr_i (idx_q), .wdata_i (grey_new),
    .re_i (rd_en), .raddr_i (idx_q), .rdata_o (grey_rd)
  );

  ppu_ram #(.Width(ALPHA_W), .Depth(POOL_SIZE)) u_alpha_ram (
    .clk_i (clk_i), .we_i (alpha_we), .waddr_i (idx_q), .wdata_i (alpha_wd),
    .re_i (rd_en), .raddr_i (idx_q), .rdata_o (alpha_rd)
  );

  always_comb begin
    cur_live = '{
      result_kind: KIND_LIVE,
      slot:        SLOT_W'(idx_q),
      position_x:  px_q,
      position_y:  py_q,
      grey_level:  grey_rd,
      alpha:       alu_y[ALPHA_W-1:0],
      last:        1'b0
    };
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      item_q   <= '0;
      idx_q    <= '0;
      cnt_q    <= '0;
      srch_q   <= '0;
      alive_q  <= '0;
      acc_q    <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      fade_q   <= '0;
      px_q     <= '0;
      py_q     <= '0;
      pend_q   <= '0;
      pend_v_q <= 1'b0;
      res_q    <= '0;
      res_v_q  <= 1'b0;
    end else begin
      res_v_q <= (state_q == ST_Y2) || (state_q == ST_END) ||
                 ((state_q == ST_AL) && pend_v_q);
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            item_q <= item_i;
            cnt_q  <= '0;
            if (item_i.command == CMD_SPAWN) begin
              idx_q   <= srch_q;
              state_q <= ST_SEARCH;
            end else begin
              idx_q   <= '0;
              state_q <= ST_MVX;
            end
          end
        end
        ST_SEARCH: begin
          if (!alive_q[idx_q]) begin
            state_q <= ST_X1;
          end else if (cnt_q == LastIdx) begin
            // pool full: reuse slot 0
            idx_q   <= '0;
            state_q <= ST_X1;
          end else begin
            idx_q <= idx_nxt;
            cnt_q <= cnt_q + IdxW'(1);
          end
        end
        ST_X1: begin
          acc_q   <= alu_y;
          state_q <= ST_X2;
        end
        ST_X2: begin
          px_q    <= alu_y[POS_W-1:0];
          state_q <= ST_Y1;
        end
        ST_Y1: begin
          acc_q   <= alu_y;
          state_q <= ST_Y2;
        end
        ST_Y2: begin
          alive_q[idx_q] <= (cfg.spawn_life != '0);
          srch_q         <= idx_q;
          res_q <= '{
            result_kind: KIND_SPAWN,
            slot:        SLOT_W'(idx_q),
            position_x:  px_q,
            position_y:  alu_y[POS_W-1:0],
            grey_level:  grey_new,
            alpha:       ALPHA_FULL,
            last:        1'b1
          };
          state_q <= ST_IDLE;
        end
        ST_MVX: begin
          acc_q   <= alu_y;
          state_q <= ST_RVX;
        end
        ST_RVX: begin
          dx_q    <= alu_y[DELTA_W-1:0];
          state_q <= ST_MVY;
        end
        ST_MVY: begin
          acc_q   <= alu_y;
          state_q <= ST_RVY;
        end
        ST_RVY: begin
          dy_q    <= alu_y[DELTA_W-1:0];
          state_q <= ST_MFD;
        end
        ST_MFD: begin
          acc_q   <= alu_y;
          state_q <= ST_RFD;
        end
        ST_RFD: begin
          fade_q  <= alu_y[ALPHA_W-1:0];
          state_q <= ST_RD;
        end
        ST_RD: begin
          state_q <= ST_LIFE;
        end
        ST_LIFE: begin
          alive_q[idx_q] <= live_now;
          if (live_now) begin
            state_q <= ST_PX;
          end else if (idx_last) begin
            state_q <= ST_END;
          end else begin
            idx_q   <= idx_nxt;
            state_q <= ST_RD;
          end
        end
        ST_PX: begin
          px_q    <= alu_y[POS_W-1:0];
          state_q <= ST_PY;
        end
        ST_PY: begin
          py_q    <= alu_y[POS_W-1:0];
          state_q <= ST_AL;
        end
        ST_AL: begin
          // hold one result back so the final one can carry last
          if (pend_v_q) begin
            res_q <= pend_q;
          end
          pend_q   <= cur_live;
          pend_v_q <= 1'b1;
          if (idx_last) begin
            state_q <= ST_END;
          end else begin
            idx_q   <= idx_nxt;
            state_q <= ST_RD;
          end
        end
        ST_END: begin
          if (pend_v_q) begin
            res_q <= '{
              result_kind: pend_q.result_kind,
              slot:        pend_q.slot,
              position_x:  pend_q.position_x,
              position_y:  pend_q.position_y,
              grey_level:  pend_q.grey_level,
              alpha:       pend_q.alpha,
              last:        1'b1
            };
          end else begin
            res_q <= '{
              result_kind: KIND_EMPTY,
              slot:        '0,
              position_x:  '0,
              position_y:  '0,
              grey_level:  '0,
              alpha:       '0,
              last:        1'b1
            };
          end
          pend_v_q <= 1'b0;
          state_q  <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/ppu_chk.sv */
// Port-level checker for particle_pool_update, bound to the top level.
// Depends on ppu_pkg and particle_pool_update_defines.svh.
`timescale 1ns / 1ps
`include "particle_pool_update_defines.svh"
module ppu_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_i,
  input logic          res_strobe_i,
  input ppu_pkg::out_t res_i
);
  import ppu_pkg::*;

  `PPU_ASSERT_NXT(a_accept_busy, start_i && !busy_i, busy_i)
  `PPU_ASSERT_NXT(a_no_early_res, start_i && !busy_i, !res_strobe_i)
  `PPU_ASSERT_IMP(a_spawn_last, res_strobe_i && (res_i.result_kind == KIND_SPAWN), res_i.last)
  `PPU_ASSERT_IMP(a_empty_shape, res_strobe_i && (res_i.result_kind == KIND_EMPTY), res_i.last && (res_i.slot == '0))
  `PPU_ASSERT_IMP(a_done_last, $fell(busy_i), res_strobe_i && res_i.last)

endmodule

bind particle_pool_update ppu_chk u_ppu_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start),
  .busy_i       (busy),
  .res_strobe_i (res_strobe_o),
  .res_i        (res_o)
);
